// ===== src/lcdw_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdw_pkg
// Shared types and constants for the LCD serial frame writer.
// ----------------------------------------------------------------------------
package lcdw_pkg;

  localparam int unsigned HALF_W          = 10;
  localparam int unsigned HALF_RESET      = 100;
  localparam int unsigned CMD_W           = 12;
  localparam int unsigned NIB_W           = 4;
  localparam int unsigned FRAME_W         = 13;
  localparam int unsigned BITCNT_W        = 4;
  localparam int unsigned RAM_NIBBLES_DEF = 32;
  localparam int unsigned APB_ADDR_W      = 3;
  localparam int unsigned APB_DATA_W      = 32;

  // Register indexes (paddr[2] selects the word)
  localparam logic REG_STROBE_HALF = 1'b0;

  // Write header 101 followed by start address 000000
  localparam logic [8:0] WRITE_HEADER = 9'b101_000000;

  // Frame lengths in bits
  localparam logic [BITCNT_W-1:0] CMD_FRAME_BITS  = 4'd13;
  localparam logic [BITCNT_W-1:0] HDR_FRAME_BITS  = 4'd13;
  localparam logic [BITCNT_W-1:0] NIB_FRAME_BITS  = 4'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOW,
    ST_HIGH,
    ST_OUT
  } seq_state_e;

  typedef struct packed {
    logic              start;
    logic [HALF_W-1:0] half;
  } tmr_ctrl_t;

endpackage

// ===== src/lcd_serial_frame_writer.sv =====
// ----------------------------------------------------------------------------
// lcd_serial_frame_writer
// Three-wire LCD link serializer: command frames and display nibble bursts.
// ----------------------------------------------------------------------------
// Each bit runs a strobe low half and a strobe high half, both timed by the
// strobe half-period register, then is held as a result word while the output stalls.
// Only one item of n bits (13 or 4) is in flight: the input stalls until its
// last word is taken, and every bit reuses the single strobe half-period timer.
// A rejected command returns its one word in the next cycle; input reopens once it is taken.
// Reset: no burst open, nibble count 0, strobe half period register 100.
module lcd_serial_frame_writer #(
  parameter int unsigned RAM_NIBBLES = lcdw_pkg::RAM_NIBBLES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              cmd_i,
  input  logic [lcdw_pkg::CMD_W-1:0]        command_word_i,
  input  logic [lcdw_pkg::NIB_W-1:0]        nibble_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              wire_bit_o,
  output logic                              frame_end_o,
  output logic                              last_o,
  output logic                              rejected_o,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lcdw_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lcdw_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lcdw_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import lcdw_pkg::*;

  // Count must reach RAM_NIBBLES itself before the burst closes.
  localparam int unsigned CNT_W = $clog2(RAM_NIBBLES + 1);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [HALF_W-1:0] half_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_STROBE_HALF);
  assign prdata = (paddr[2] == REG_STROBE_HALF) ?
                  APB_DATA_W'(half_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= HALF_W'(HALF_RESET);
    end else if (cfg_wr) begin
      half_q <= pwdata[HALF_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  seq_state_e          state_q, state_d;
  logic                burst_q, burst_d;
  logic [CNT_W-1:0]    ncnt_q, ncnt_d;
  logic [FRAME_W-1:0]  shreg_q, shreg_d;       // next bit to send at the MSB
  logic [BITCNT_W-1:0] left_q, left_d;         // bits still to send
  logic                fend_q, fend_d;         // frame closes on the last bit
  logic                ov_q, ov_d;
  logic                bit_q, bit_d;
  logic                fe_q, fe_d;
  logic                last_q, last_d;
  logic                rej_q, rej_d;

  tmr_ctrl_t           tmr_ctrl;
  logic                tmr_done;

  logic                in_acc;
  logic [CNT_W:0]      ncnt_inc;
  logic                burst_full;
  logic [NIB_W-1:0]    nib_rev;

  lcdw_half_timer u_timer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (tmr_ctrl),
    .done_o (tmr_done)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign ncnt_inc   = {1'b0, ncnt_q} + (CNT_W+1)'(1);
  assign burst_full = (ncnt_inc >= (CNT_W+1)'(RAM_NIBBLES));

  // Nibbles go out least significant bit first: reverse so the shifter
  // always sends from its top bit.
  always_comb begin
    for (int k = 0; k < NIB_W; k++) begin
      nib_rev[k] = nibble_i[NIB_W-1-k];
    end
  end

  always_comb begin
    state_d       = state_q;
    burst_d       = burst_q;
    ncnt_d        = ncnt_q;
    shreg_d       = shreg_q;
    left_d        = left_q;
    fend_d        = fend_q;
    ov_d          = ov_q;
    bit_d         = bit_q;
    fe_d          = fe_q;
    last_d        = last_q;
    rej_d         = rej_q;
    tmr_ctrl.start = 1'b0;
    tmr_ctrl.half  = half_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!cmd_i && burst_q) begin
            // Drop the command; answer with a single rejected word.
            ov_d    = 1'b1;
            bit_d   = 1'b0;
            fe_d    = 1'b0;
            last_d  = 1'b1;
            rej_d   = 1'b1;
            state_d = ST_OUT;
          end else begin
            if (!cmd_i) begin
              shreg_d = {command_word_i, 1'b0};
              left_d  = CMD_FRAME_BITS;
              fend_d  = 1'b1;
            end else begin
              if (!burst_q) begin
                shreg_d = {WRITE_HEADER, nib_rev};
                left_d  = HDR_FRAME_BITS;
              end else begin
                shreg_d = {nib_rev, {(FRAME_W-NIB_W){1'b0}}};
                left_d  = NIB_FRAME_BITS;
              end
              fend_d = burst_full;
              if (burst_full) begin
                burst_d = 1'b0;
                ncnt_d  = '0;
              end else begin
                burst_d = 1'b1;
                ncnt_d  = ncnt_inc[CNT_W-1:0];
              end
            end
            tmr_ctrl.start = 1'b1;
            state_d        = ST_LOW;
          end
        end
      end
      ST_LOW: begin
        // Strobe low half done: start the high half.
        if (tmr_done) begin
          tmr_ctrl.start = 1'b1;
          state_d        = ST_HIGH;
        end
      end
      ST_HIGH: begin
        // Rising strobe latches the bit: present it as a result word.
        if (tmr_done) begin
          ov_d    = 1'b1;
          bit_d   = shreg_q[FRAME_W-1];
          last_d  = (left_q == BITCNT_W'(1));
          fe_d    = (left_q == BITCNT_W'(1)) && fend_q;
          rej_d   = 1'b0;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // Hold the word until taken, then advance to the next bit.
        if (!out_stall_i) begin
          ov_d = 1'b0;
          if (last_q) begin
            state_d = ST_IDLE;
          end else begin
            shreg_d        = {shreg_q[FRAME_W-2:0], 1'b0};
            left_d         = left_q - BITCNT_W'(1);
            tmr_ctrl.start = 1'b1;
            state_d        = ST_LOW;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      burst_q <= 1'b0;
      ncnt_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      burst_q <= burst_d;
      ncnt_q  <= ncnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    left_q  <= left_d;
    fend_q  <= fend_d;
    bit_q   <= bit_d;
    fe_q    <= fe_d;
    last_q  <= last_d;
    rej_q   <= rej_d;
  end

  assign out_valid_o = ov_q;
  assign wire_bit_o  = bit_q;
  assign frame_end_o = fe_q;
  assign last_o      = last_q;
  assign rejected_o  = rej_q;

endmodule

// ===== src/lcdw_half_timer.sv =====
// ----------------------------------------------------------------------------
// lcdw_half_timer
// Down-counter shared by both halves of every write strobe pulse.
// ----------------------------------------------------------------------------
module lcdw_half_timer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lcdw_pkg::tmr_ctrl_t ctrl_i,
  output logic              done_o
);
  import lcdw_pkg::*;

  logic [HALF_W-1:0] cnt_q, cnt_d;
  logic              run_q, run_d;

  assign done_o = run_q && (cnt_q == '0);

  always_comb begin
    cnt_d = cnt_q;
    run_d = run_q;
    if (ctrl_i.start) begin
      cnt_d = ctrl_i.half - HALF_W'(1);
      run_d = 1'b1;
    end else if (done_o) begin
      run_d = 1'b0;
    end else if (run_q) begin
      cnt_d = cnt_q - HALF_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== src/lcdw_checker.sv =====
// ----------------------------------------------------------------------------
// lcdw_checker
// Port-level checks for the LCD serial frame writer, bound to the top level.
// ----------------------------------------------------------------------------
module lcdw_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic wire_bit_o,
  input logic frame_end_o,
  input logic last_o,
  input logic rejected_o
);

  // A rejected command carries nothing but its flags.
  a_reject_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> last_o && !wire_bit_o && !frame_end_o)
    else $error("rejected word carries data");

  // Chip select only releases on the final bit of an item.
  a_fend_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> last_o)
    else $error("frame end before last bit");

  // No new item is taken while a word is pending.
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while word pending");

  // An accepted item keeps the input closed in the next cycle.
  a_busy_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open right after accept");

  // A stalled word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(wire_bit_o)
      && $stable(last_o) && $stable(frame_end_o) && $stable(rejected_o))
    else $error("stalled word changed");

endmodule

bind lcd_serial_frame_writer lcdw_checker u_lcdw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .wire_bit_o  (wire_bit_o),
  .frame_end_o (frame_end_o),
  .last_o      (last_o),
  .rejected_o  (rejected_o)
);
